FILE: rtl/utf8_to_utf16_bmp_decoder_top_assert.svh
// Assertion macros for the UTF-8 to UTF-16 decoder.
`ifndef UTF8_TO_UTF16_BMP_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_BMP_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define UBD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder assertion failed");
// Next-cycle implication, checked outside reset.
`define UBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder assertion failed");
`else
`define UBD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define UBD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/ubd_pkg.sv
// Types, constants and helper functions shared by the decoder modules.
`timescale 1ns / 1ps

package ubd_pkg;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [15:0] SURR_LO     = 16'hD800;
  localparam logic [15:0] SURR_HI     = 16'hDFFF;
  localparam int unsigned CMD_DEPTH   = 4;
  localparam int unsigned OUT_DEPTH   = 8;

  // Lead length codes
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;

  // Work for the back end: replacements owed, then an optional tail item.
  typedef struct packed {
    logic [2:0]  nrep;
    logic        has_tail;
    logic        tail_end;
    logic [15:0] tail_unit;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
    logic [15:0] unit_count;
  } res_t;

  // Open-sequence status from the front end.
  typedef struct packed {
    logic [2:0] expected_len;
    logic [2:0] bytes_seen;
  } seq_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'h80)      len = LEN_ASCII;
    else if (b < 8'hC0) len = LEN_NONE;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else if (b < 8'hFE) len = 3'd6;
    else                len = LEN_NONE;
    return len;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    logic [7:0] m;
    case (len)
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      default: m = 8'h01;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] to_unit(input logic [30:0] v);
    logic [15:0] u;
    if (v[30:16] != 15'd0)                      u = REPLACEMENT;
    else if (v[15:0] >= SURR_LO && v[15:0] <= SURR_HI) u = REPLACEMENT;
    else                                        u = v[15:0];
    return u;
  endfunction

endpackage

FILE: rtl/utf8_to_utf16_bmp_decoder_top.sv
// Top level of the UTF-8 to UTF-16 (BMP) decoder.
`timescale 1ns / 1ps
//
// Usage:
//  - Input queue: drive data_byte with push; the byte is taken when push is
//    high and full is low. A 0x00 byte ends the string.
//  - Result queue: while empty is low, code_unit / end_of_string / unit_count
//    show the oldest result; pop takes it. The end item has code_unit 0 and
//    the kept unit count, capped at the budget.
//  - max_units_we / max_units_wdata write the per-string unit budget; write
//    it only while the block is drained.
//  - Path: a request goes from the front end into the command queue, and
//    then from the back end into the result queue.
//  - Throughput: one byte per cycle while full is low. The back end takes
//    owed results one at a time (emitted or dropped for budget); a broken
//    sequence owes up to six, and the 4-entry command queue absorbs that.
//  - A stalled receiver fills the 8-entry result queue, then the command
//    queue, and then full goes high.
//  - Reset: both queues empty, no sequence open, count zero, budget 65535.
//
module utf8_to_utf16_bmp_decoder_top #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic        end_of_string,
  output logic [15:0] unit_count,
  input  logic        max_units_we,
  input  logic [15:0] max_units_wdata
);
  import ubd_pkg::*;

`include "utf8_to_utf16_bmp_decoder_top_assert.svh"

  logic [15:0] max_units;
  logic        accept;
  logic        cmd_valid;
  cmd_t        cmd;
  seq_t        seq_status;
  logic        cmd_full;
  logic        cmd_empty;
  logic        cmd_pop;
  cmd_t        cmd_head;
  logic        out_full;
  logic        res_push;
  res_t        res;
  res_t        res_head;
  logic [2:0]  rep_done;

  // budget register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= 16'hFFFF;
    end else if (max_units_we) begin
      max_units <= max_units_wdata;
    end
  end

  // a request is taken whenever the command queue has room
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  ubd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .status    (seq_status)
  );

  ubd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_valid),
    .wdata (cmd),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  ubd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .max_units  (max_units),
    .cmd_empty  (cmd_empty),
    .head       (cmd_head),
    .cmd_pop    (cmd_pop),
    .out_full   (out_full),
    .res_push   (res_push),
    .res        (res),
    .rep_done_q (rep_done)
  );

  // result queue decouples the receiver from the back end
  ubd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .pop   (pop),
    .rdata (res_head),
    .full  (out_full),
    .empty (empty)
  );

  assign code_unit     = res_head.code_unit;
  assign end_of_string = res_head.end_of_string;
  assign unit_count    = res_head.unit_count;

  // open sequence always has its lead counted and is not yet complete
  `UBD_ASSERT_IMPLY(a_seq_open, clk, rst, seq_status.expected_len != LEN_NONE,
    seq_status.bytes_seen != 3'd0 && seq_status.bytes_seen < seq_status.expected_len)

  // replacement progress only exists against a queued command, within its count
  `UBD_ASSERT_IMPLY(a_rep_bound, clk, rst, 1'b1,
    (cmd_empty && rep_done == 3'd0) || (!cmd_empty && rep_done <= cmd_head.nrep))

  // every kept unit carries a nonzero running count
  `UBD_ASSERT_IMPLY(a_unit_count, clk, rst, !empty && !end_of_string,
    unit_count != 16'd0)

endmodule

FILE: rtl/ubd_fifo.sv
// Small register-based FIFO used for the command and result queues.
`timescale 1ns / 1ps

module ubd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ubd_front.sv
// Front end: takes bytes, tracks the open sequence, issues back-end commands.
`timescale 1ns / 1ps

module ubd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  output logic          cmd_valid,
  output ubd_pkg::cmd_t cmd,
  output ubd_pkg::seq_t status
);
  import ubd_pkg::*;

  logic [2:0]  expected_len, expected_len_next;
  logic [2:0]  bytes_seen, bytes_seen_next;
  logic [30:0] accum_value, accum_value_next;
  logic [30:0] acc_shift;
  logic [2:0]  seen_inc;
  logic [2:0]  len;
  logic        is_cont;

  assign is_cont   = data_byte inside {[8'h80:8'hBF], [8'hFE:8'hFF]};
  assign acc_shift = {accum_value[24:0], data_byte[5:0]};
  assign seen_inc  = bytes_seen + 3'd1;
  assign len       = lead_len(data_byte);
  assign status    = '{expected_len: expected_len, bytes_seen: bytes_seen};

  always_comb begin
    cmd               = '0;
    expected_len_next = expected_len;
    bytes_seen_next   = bytes_seen;
    accum_value_next  = accum_value;
    if (expected_len != LEN_NONE && is_cont) begin
      accum_value_next = acc_shift;
      bytes_seen_next  = seen_inc;
      if (seen_inc >= expected_len) begin
        cmd.has_tail      = 1'b1;
        cmd.tail_unit     = to_unit(acc_shift);
        expected_len_next = LEN_NONE;
        bytes_seen_next   = '0;
        accum_value_next  = '0;
      end
    end else begin
      // no continuation taken: a broken sequence owes one replacement per byte held, then the byte is decoded afresh
      cmd.nrep          = (expected_len != LEN_NONE) ? bytes_seen : 3'd0;
      expected_len_next = LEN_NONE;
      bytes_seen_next   = '0;
      accum_value_next  = '0;
      if (data_byte == 8'h00) begin
        cmd.has_tail = 1'b1;
        cmd.tail_end = 1'b1;
      end else begin
        case (len)
          LEN_ASCII: begin
            cmd.has_tail  = 1'b1;
            cmd.tail_unit = {8'h00, data_byte};
          end
          LEN_NONE: begin
            cmd.has_tail  = 1'b1;
            cmd.tail_unit = REPLACEMENT;
          end
          default: begin
            expected_len_next = len;
            bytes_seen_next   = 3'd1;
            accum_value_next  = 31'(data_byte & lead_mask(len));
          end
        endcase
      end
    end
  end

  assign cmd_valid = accept && (cmd.has_tail || cmd.nrep != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_len <= LEN_NONE;
      bytes_seen   <= '0;
      accum_value  <= '0;
    end else if (accept) begin
      expected_len <= expected_len_next;
      bytes_seen   <= bytes_seen_next;
      accum_value  <= accum_value_next;
    end
  end

endmodule

FILE: rtl/ubd_back.sv
// Back end: expands commands into result items and applies the unit budget.
`timescale 1ns / 1ps

module ubd_back #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   max_units,
  input  logic          cmd_empty,
  input  ubd_pkg::cmd_t head,
  output logic          cmd_pop,
  input  logic          out_full,
  output logic          res_push,
  output ubd_pkg::res_t res,
  output logic [2:0]    rep_done_q
);
  import ubd_pkg::*;

  localparam int unsigned WB = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] kept_count, kept_count_next;
  logic [COUNT_BITS-1:0] kept_inc;
  logic [2:0]            rep_done, rep_done_next;
  logic [WB-1:0]         kept_ext, inc_ext, max_ext, fin_ext;
  logic                  step;
  logic                  is_rep;
  logic                  room;

  assign kept_inc   = kept_count + COUNT_BITS'(1);
  assign kept_ext   = WB'(kept_count);
  assign inc_ext    = WB'(kept_inc);
  assign max_ext    = WB'(max_units);
  assign fin_ext    = (kept_ext > max_ext) ? max_ext : kept_ext;
  assign room       = (kept_ext < max_ext) && (kept_count != '1);
  assign step       = !cmd_empty && !out_full;
  assign is_rep     = (rep_done != head.nrep);
  assign rep_done_q = rep_done;

  always_comb begin
    res             = '0;
    res_push        = 1'b0;
    cmd_pop         = 1'b0;
    kept_count_next = kept_count;
    rep_done_next   = rep_done;
    if (step) begin
      if (is_rep) begin
        rep_done_next = rep_done + 3'd1;
        if (room) begin
          kept_count_next = kept_inc;
          res.code_unit   = REPLACEMENT;
          res.unit_count  = inc_ext[15:0];
          res_push        = 1'b1;
        end
        if (rep_done + 3'd1 == head.nrep && !head.has_tail) begin
          cmd_pop       = 1'b1;
          rep_done_next = '0;
        end
      end else begin
        cmd_pop       = 1'b1;
        rep_done_next = '0;
        if (head.tail_end) begin
          res.end_of_string = 1'b1;
          res.unit_count    = fin_ext[15:0];
          res_push          = 1'b1;
          kept_count_next   = '0;
        end else if (room) begin
          kept_count_next = kept_inc;
          res.code_unit   = head.tail_unit;
          res.unit_count  = inc_ext[15:0];
          res_push        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      rep_done   <= '0;
    end else begin
      kept_count <= kept_count_next;
      rep_done   <= rep_done_next;
    end
  end

endmodule

FILE: tb/utf8_to_utf16_bmp_decoder_checker.sv
// Checker for the UTF-8 to UTF-16 decoder: predicts and compares result items.
`timescale 1ns / 1ps

module utf8_to_utf16_bmp_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] code_unit,
  input  logic        end_of_string,
  input  logic [15:0] unit_count,
  input  logic        max_units_we,
  input  logic [15:0] max_units_wdata,
  output int          fail_count,
  output int          expected_left,
  output int          units_checked
);
  import ubd_pkg::*;

  localparam logic [7:0]  TERMINATOR     = 8'h00;
  localparam logic [15:0] COUNT_TOP      = 16'hFFFF;
  localparam logic [15:0] BUDGET_AT_RST  = 16'hFFFF;
  localparam int          SHOWN_MISMATCH = 10;

  res_t        due_units[$];
  logic [2:0]  open_len;
  logic [2:0]  held_bytes;
  logic [30:0] gathered;
  logic [15:0] kept;
  logic [15:0] budget;

  function automatic logic is_trailer(input logic [7:0] b);
    return (b >= 8'h80 && b <= 8'hBF) || b >= 8'hFE;
  endfunction

  function automatic logic [2:0] seq_length(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'h80)      len = LEN_ASCII;
    else if (b < 8'hC0) len = LEN_NONE;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else if (b < 8'hFE) len = 3'd6;
    else                len = LEN_NONE;
    return len;
  endfunction

  function automatic logic [7:0] lead_bits(input logic [2:0] len);
    logic [7:0] m;
    case (len)
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      default: m = 8'h01;
    endcase
    return m;
  endfunction

  // Surrogates (bounds inclusive) and anything past the BMP collapse to U+FFFD.
  function automatic logic [15:0] bmp_unit(input logic [30:0] v);
    logic [15:0] u;
    if (v > 31'h0000FFFF)                      u = REPLACEMENT;
    else if (v >= 31'hD800 && v <= 31'hDFFF)   u = REPLACEMENT;
    else                                       u = v[15:0];
    return u;
  endfunction

  function automatic void close_seq();
    open_len   = LEN_NONE;
    held_bytes = 3'd0;
    gathered   = 31'd0;
  endfunction

  // Budget exhausted or count at its top: the unit is silently dropped.
  function automatic void keep_unit(input logic [15:0] u);
    res_t r;
    if (kept < budget && kept < COUNT_TOP) begin
      kept            = kept + 16'd1;
      r.code_unit     = u;
      r.end_of_string = 1'b0;
      r.unit_count    = kept;
      due_units.push_back(r);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    res_t       r;
    logic [2:0] len;
    logic       fresh;
    fresh = 1'b1;
    if (open_len != LEN_NONE) begin
      if (is_trailer(b)) begin
        fresh      = 1'b0;
        gathered   = {gathered[24:0], b[5:0]};
        held_bytes = held_bytes + 3'd1;
        if (held_bytes >= open_len) begin
          keep_unit(bmp_unit(gathered));
          close_seq();
        end
      end else begin
        // broken sequence: one replacement per held byte, then retry the byte
        for (int i = 0; i < held_bytes && i < 5; i++) keep_unit(REPLACEMENT);
        close_seq();
      end
    end
    if (fresh) begin
      if (b == TERMINATOR) begin
        r.code_unit     = 16'd0;
        r.end_of_string = 1'b1;
        r.unit_count    = (kept > budget) ? budget : kept;
        due_units.push_back(r);
        kept = 16'd0;
        close_seq();
      end else begin
        len = seq_length(b);
        if (len == LEN_ASCII) begin
          keep_unit({8'h00, b});
        end else if (len == LEN_NONE) begin
          keep_unit(REPLACEMENT);
        end else begin
          open_len   = len;
          held_bytes = 3'd1;
          gathered   = {23'd0, b & lead_bits(len)};
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      due_units.delete();
      close_seq();
      kept          = 16'd0;
      budget        = BUDGET_AT_RST;
      fail_count    = 0;
      units_checked = 0;
    end else begin
      if (max_units_we) budget = max_units_wdata;
      if (pop && !empty) begin
        units_checked++;
        if (due_units.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCH)
            $display("%0t: unexpected result unit %h end %b count %0d",
                     $realtime, code_unit, end_of_string, unit_count);
        end else begin
          want = due_units.pop_front();
          if (want.code_unit !== code_unit || want.end_of_string !== end_of_string ||
              want.unit_count !== unit_count) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCH)
              $display("%0t: mismatch, expected unit %h end %b count %0d, got %h %b %0d",
                       $realtime, want.code_unit, want.end_of_string, want.unit_count,
                       code_unit, end_of_string, unit_count);
          end
        end
      end
      if (push && !full) decode_byte(data_byte);
    end
    expected_left = due_units.size();
  end

endmodule

FILE: tb/tb_utf8_to_utf16_bmp_decoder_top.sv
// Testbench top for the UTF-8 to UTF-16 decoder: byte stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_bmp_decoder_top;

  localparam logic [7:0]  TERMINATOR    = 8'h00;
  localparam int          RESET_CYCLES  = 12;
  // Dropped units still cost back-end cycles after the last result is out:
  // up to four queued commands, each owing up to five replacements and a tail.
  localparam int          SETTLE_CYCLES = 32;
  localparam int          TAIL_CYCLES   = 20;
  // Long receiver hold-off: far more than the 8 + 4 entries of buffering.
  localparam int          HOLD_CYCLES   = 300;
  // Time limit for the whole run, in ns.
  localparam int unsigned RUN_LIMIT_NS  = 800000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        empty;
  logic        pop;
  logic [15:0] code_unit;
  logic        end_of_string;
  logic [15:0] unit_count;
  logic        max_units_we;
  logic [15:0] max_units_wdata;

  int fail_count;
  int expected_left;
  int units_checked;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   bytes_sent    = 0;
  logic hold_request  = 1'b0;
  logic hold_taken    = 1'b0;
  int   hold_left     = 0;

  // Byte plan for the sequence in flight.
  logic [7:0] plan[$];

  utf8_to_utf16_bmp_decoder_top dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .data_byte       (data_byte),
    .empty           (empty),
    .pop             (pop),
    .code_unit       (code_unit),
    .end_of_string   (end_of_string),
    .unit_count      (unit_count),
    .max_units_we    (max_units_we),
    .max_units_wdata (max_units_wdata)
  );

  utf8_to_utf16_bmp_decoder_checker unit_check (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .data_byte       (data_byte),
    .empty           (empty),
    .pop             (pop),
    .code_unit       (code_unit),
    .end_of_string   (end_of_string),
    .unit_count      (unit_count),
    .max_units_we    (max_units_we),
    .max_units_wdata (max_units_wdata),
    .fail_count      (fail_count),
    .expected_left   (expected_left),
    .units_checked   (units_checked)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: pops at random, except during one long hold-off that it
  // counts itself once the stimulus asks for it.
  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Entered and left at a falling edge. push is touched once per step: the
  // caller must not have driven it in the step this starts in.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_plan();
    foreach (plan[i]) send_byte(plan[i]);
  endtask

  // Drop the request and wait until every predicted result has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
  endtask

  // Budget writes only happen with the block drained. Dropped units and a
  // trailing lead byte make no result, so let the pipeline settle first.
  task automatic set_budget(input logic [15:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    max_units_we    <= 1'b1;
    max_units_wdata <= v;
    @(negedge clk);
    max_units_we    <= 1'b0;
  endtask

  function automatic logic [7:0] lead_for(input int len);
    logic [7:0] b;
    case (len)
      2:       b = 8'($urandom_range(8'hC0, 8'hDF));
      3:       b = 8'($urandom_range(8'hE0, 8'hEF));
      4:       b = 8'($urandom_range(8'hF0, 8'hF7));
      5:       b = 8'($urandom_range(8'hF8, 8'hFB));
      default: b = 8'($urandom_range(8'hFC, 8'hFD));
    endcase
    return b;
  endfunction

  // Mostly 10xxxxxx; 0xFE / 0xFF also count as continuation bytes.
  function automatic logic [7:0] trailer();
    logic [7:0] b;
    if ($urandom_range(15) == 0) b = 8'hFE | 8'($urandom_range(1));
    else                         b = 8'($urandom_range(8'h80, 8'hBF));
    return b;
  endfunction

  // One sequence into the plan: mostly well formed with random payload,
  // plus terminators, stray continuations and truncated sequences.
  task automatic queue_sequence();
    int pick;
    int len;
    int n_tr;
    pick = $urandom_range(99);
    if (pick < 30) begin
      plan.push_back(8'($urandom_range(1, 127)));
    end else if (pick < 78) begin
      len = (pick < 45) ? 2 : (pick < 62) ? 3 : (pick < 70) ? 4 : (pick < 74) ? 5 : 6;
      if (len == 3 && $urandom_range(3) == 0) begin
        // lands in the surrogate range
        plan.push_back(8'hED);
        plan.push_back(8'($urandom_range(8'hA0, 8'hBF)));
        plan.push_back(trailer());
      end else begin
        plan.push_back(lead_for(len));
        repeat (len - 1) plan.push_back(trailer());
      end
    end else if (pick < 86) begin
      plan.push_back(TERMINATOR);
    end else if (pick < 91) begin
      plan.push_back(trailer());
    end else begin
      // cut short by a non-continuation byte (may be the terminator)
      len  = $urandom_range(2, 6);
      n_tr = $urandom_range(0, len - 2);
      plan.push_back(lead_for(len));
      repeat (n_tr) plan.push_back(trailer());
      if ($urandom_range(1) == 0) plan.push_back(8'($urandom_range(0, 127)));
      else                        plan.push_back(8'($urandom_range(8'hC0, 8'hFD)));
    end
  endtask

  task automatic send_random(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      plan.delete();
      queue_sequence();
      send_plan();
      sent += plan.size();
    end
  endtask

  initial begin
    rst             = 1'b1;
    push            = 1'b0;
    data_byte       = 8'h00;
    pop             = 1'b0;
    max_units_we    = 1'b0;
    max_units_wdata = 16'h0000;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ASCII, 2/3/4-byte forms, both surrogate bounds, above-BMP,
    // stray continuation, 0xFE as a lead, a broken sequence, a terminator
    // inside an open sequence, then the budget cut below the kept count
    // mid-string so the end request reports the smaller budget.
    send_idle_pct = 26;
    recv_idle_pct <= 79;
    set_budget(16'hFFFF);
    plan = '{8'h41, 8'hC2, 8'hA9, 8'hED, 8'hA0, 8'h80, 8'hED, 8'hBF, 8'hBF,
             8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFE, 8'hE2, 8'h82, 8'h41,
             8'hF4, 8'h8F, 8'h00, 8'h41, 8'h42, 8'h43};
    send_plan();
    set_budget(16'd2);
    plan = '{8'h44, TERMINATOR};
    send_plan();

    // Full budget; the sender pauses half way until everything is back.
    set_budget(16'hFFFF);
    send_random(40);
    wait_drained();
    send_random(40);

    // Idle ratios swap: sender slow, receiver eager.
    send_idle_pct = 79;
    recv_idle_pct <= 26;
    set_budget(16'd4);
    send_random(70);
    set_budget(16'd0);
    send_random(40);

    // No idling at all.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    set_budget(16'd1);
    send_random(40);

    // Receiver stops for a long stretch while bytes keep coming, so both
    // queues fill and full backs up the sender.
    set_budget(16'hFFFF);
    hold_request <= 1'b1;
    send_random(60);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d bytes over budgets 65535, 2, 4, 0 and 1, %0d results checked,",
             bytes_sent, units_checked);
    $display("with idling on each side, none at all, and a long receiver hold-off.");
    if (fail_count == 0 && expected_left == 0) begin
      $display("** utf8_to_utf16_bmp_decoder_top: PASSED **");
    end else begin
      $display("** utf8_to_utf16_bmp_decoder_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d results outstanding.", expected_left);
    $display("** utf8_to_utf16_bmp_decoder_top: FAILED **");
    $finish;
  end

endmodule
